// ===== rtl/bsst_pkg.sv =====
// ----------------------------------------------------------------------------
// Buffer slot stage tracker package
// Pool size, field widths, command and stage codes shared by the block.
// ----------------------------------------------------------------------------
package bsst_pkg;

	localparam int SLOT_COUNT = 16;

	// Widths of the word fields on the channels.
	localparam int CMD_W        = 2;
	localparam int STAGE_W      = 2;
	localparam int SLOT_FIELD_W = 4;

	// Only the slots that the index field can name are tracked; the rest are
	// not stored at all.
	localparam int SLOT_FIELD_LIMIT = 1 << SLOT_FIELD_W;
	localparam int USABLE_SLOTS     = (SLOT_COUNT < SLOT_FIELD_LIMIT) ?
		SLOT_COUNT : SLOT_FIELD_LIMIT;
	localparam int SLOT_W           = (USABLE_SLOTS > 1) ? $clog2(USABLE_SLOTS) : 1;

	localparam logic [CMD_W-1:0] CMD_CLAIM   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SET     = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

	localparam logic [STAGE_W-1:0] STAGE_UNUSED   = 2'd0;
	localparam logic [STAGE_W-1:0] STAGE_PENDING  = 2'd1;
	localparam logic [STAGE_W-1:0] STAGE_ESCAPING = 2'd2;
	localparam logic [STAGE_W-1:0] STAGE_UNSENT   = 2'd3;

	typedef logic [STAGE_W-1:0] stage_t;
	typedef logic [SLOT_W-1:0]  slot_idx_t;

endpackage

// ===== rtl/bsst_if.sv =====
// ----------------------------------------------------------------------------
// Buffer slot stage tracker channels
// Command channel and result channel, each a valid/ready handshake.
// ----------------------------------------------------------------------------
interface bsst_req_if;
	logic                             valid;
	logic                             ready;
	logic [bsst_pkg::CMD_W-1:0]        cmd;
	logic [bsst_pkg::STAGE_W-1:0]      stage_sel;
	logic [bsst_pkg::SLOT_FIELD_W-1:0] slot_sel;

	modport source (output valid, cmd, stage_sel, slot_sel, input ready);
	modport sink   (input valid, cmd, stage_sel, slot_sel, output ready);
endinterface

interface bsst_rsp_if;
	logic                             valid;
	logic                             ready;
	logic                             found;
	logic [bsst_pkg::SLOT_FIELD_W-1:0] slot_out;

	modport source (output valid, found, slot_out, input ready);
	modport sink   (input valid, found, slot_out, output ready);
endinterface

// ===== rtl/buffer_slot_stage_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// Buffer slot stage tracker
// Tracks stage and busy bit of a pool of buffer slots; claim, set, release.
// ----------------------------------------------------------------------------
// Usage: commands arrive on req (cmd, stage_sel, slot_sel) and each one gives
// exactly one word on rsp (found, slot_out), in order.
// Set-stage, release and unknown commands are done at the accepting edge and
// their result word is valid in the next cycle.
// A claim walks the slots from the lowest index, one slot per cycle through
// a single stage/busy comparator, and takes the first slot in the wanted
// stage whose busy bit is clear; if there is none it reports not found. No
// command is taken while a scan runs; other commands are taken one every
// cycle while the receiver takes each result.
// req.ready is high when no scan is running and the result register is empty
// or being emptied in the same cycle, so a new command may be taken while the
// receiver takes the previous result. While the receiver stalls, the result
// word holds and no further command is taken until it is.
// Reset puts every slot in the unused stage with its busy bit clear, empties
// the result register and leaves the block ready at once.
// ----------------------------------------------------------------------------
module buffer_slot_stage_tracker_unit (
	input  logic            clk,
	input  logic            arst_n,
	bsst_req_if.sink        req,
	bsst_rsp_if.source      rsp
);
	import bsst_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	localparam slot_idx_t LAST_IDX = SLOT_W'(USABLE_SLOTS - 1);

	state_t                  state_q;
	stage_t                  stage_q [USABLE_SLOTS];
	logic [USABLE_SLOTS-1:0] busy_q;
	slot_idx_t               scan_idx_q;
	stage_t                  want_q;
	logic                    rsp_valid_q;
	logic                    found_q;
	logic [SLOT_FIELD_W-1:0] slot_out_q;

	logic                    accept;
	logic                    sel_in_pool;
	slot_idx_t               sel_idx;
	logic                    hit;
	logic                    rsp_load;

	assign req.ready   = (state_q == ST_IDLE) && (!rsp_valid_q || rsp.ready);
	assign accept      = req.valid && req.ready;
	assign sel_in_pool = ({1'b0, req.slot_sel} < (SLOT_FIELD_W + 1)'(USABLE_SLOTS));
	assign sel_idx     = req.slot_sel[SLOT_W-1:0];

	// The shared comparator: the slot under the scan pointer is a candidate.
	assign hit = (stage_q[scan_idx_q] == want_q) && !busy_q[scan_idx_q];

	// A result word is loaded by any non-claim command and by the end of a scan.
	assign rsp_load = (accept && (req.cmd != CMD_CLAIM)) ||
		((state_q == ST_SCAN) && (hit || (scan_idx_q == LAST_IDX)));

	assign rsp.valid    = rsp_valid_q;
	assign rsp.found    = found_q;
	assign rsp.slot_out = slot_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			busy_q      <= '0;
			rsp_valid_q <= 1'b0;
			found_q     <= 1'b0;
			slot_out_q  <= '0;
			want_q      <= STAGE_UNUSED;
			scan_idx_q  <= '0;
			for (int i = 0; i < USABLE_SLOTS; i++) begin
				stage_q[i] <= STAGE_UNUSED;
			end
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req.cmd)
							CMD_CLAIM: begin
								want_q     <= req.stage_sel;
								scan_idx_q <= '0;
								state_q    <= ST_SCAN;
							end
							CMD_SET: begin
								if (sel_in_pool) begin
									stage_q[sel_idx] <= req.stage_sel;
									busy_q[sel_idx]  <= 1'b0;
								end
								found_q    <= sel_in_pool;
								slot_out_q <= req.slot_sel;
							end
							CMD_RELEASE: begin
								if (sel_in_pool) begin
									busy_q[sel_idx] <= 1'b0;
								end
								found_q    <= sel_in_pool;
								slot_out_q <= req.slot_sel;
							end
							default: begin
								found_q    <= 1'b0;
								slot_out_q <= req.slot_sel;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (hit) begin
						busy_q[scan_idx_q] <= 1'b1;
						found_q            <= 1'b1;
						slot_out_q         <= SLOT_FIELD_W'(scan_idx_q);
						state_q            <= ST_IDLE;
					end else if (scan_idx_q == LAST_IDX) begin
						found_q    <= 1'b0;
						slot_out_q <= '0;
						state_q    <= ST_IDLE;
					end else begin
						scan_idx_q <= scan_idx_q + SLOT_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/bsst_checker.sv =====
// ----------------------------------------------------------------------------
// Buffer slot stage tracker checker
// Port-level checks on the tracker, attached to the tracker unit by bind.
// ----------------------------------------------------------------------------
module bsst_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	input  logic                             req_ready,
	input  logic [bsst_pkg::CMD_W-1:0]        cmd,
	input  logic [bsst_pkg::SLOT_FIELD_W-1:0] slot_sel,
	input  logic                             rsp_valid,
	input  logic                             rsp_ready,
	input  logic                             found,
	input  logic [bsst_pkg::SLOT_FIELD_W-1:0] slot_out
);
	import bsst_pkg::*;

	// A stalled result word must hold.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(found) && $stable(slot_out))
		else $error("result word changed while stalled");

	// No result is shown during reset.
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !rsp_valid)
		else $error("result valid during reset");

	// A new command is only taken when the result register is empty or being emptied.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |-> !rsp_valid || rsp_ready)
		else $error("command accepted over an untaken result");

	// Set and release of a slot in the pool answer in the next cycle, echoing it.
	a_set_release: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (cmd == CMD_SET || cmd == CMD_RELEASE) &&
		({1'b0, slot_sel} < (SLOT_FIELD_W + 1)'(USABLE_SLOTS))
		|=> rsp_valid && found && (slot_out == $past(slot_sel)))
		else $error("set or release result wrong");

	// Other commands than a claim answer in the next cycle.
	a_quick_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (cmd != CMD_CLAIM) |=> rsp_valid)
		else $error("missing result after non-claim command");

endmodule

bind buffer_slot_stage_tracker_unit bsst_checker u_bsst_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.cmd       (req.cmd),
	.slot_sel  (req.slot_sel),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.found     (rsp.found),
	.slot_out  (rsp.slot_out)
);
